[hdl/csv_stream_tokenizer_core_assert.svh]
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_core_assert
// Assertion macros for the CSV tokenizer. Each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef CSV_STREAM_TOKENIZER_CORE_ASSERT_SVH
`define CSV_STREAM_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CSVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/csvt_pkg.sv]
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared character codes and item types for the CSV stream tokenizer.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int unsigned CharW  = 16;
  localparam int unsigned CountW = 32;
  localparam int unsigned LimitW = 24;

  localparam logic [CharW-1:0] BomCode  = 16'hFEFF;
  localparam logic [CharW-1:0] CharQuote = 16'h0022;
  localparam logic [CharW-1:0] CharComma = 16'h002C;
  localparam logic [CharW-1:0] CharCr    = 16'h000D;
  localparam logic [CharW-1:0] CharLf    = 16'h000A;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             end_of_text;
  } in_item_t;

  typedef struct packed {
    logic              char_valid;
    logic [CharW-1:0]  char_out;
    logic              field_end;
    logic              row_end;
    logic              text_end;
    logic              row_is_header;
    logic              row_kept;
    logic [CountW-1:0] data_row_count;
  } result_t;

endpackage

[hdl/csvt_in_if.sv]
// ----------------------------------------------------------------------------
// csvt_in_if
// Character channel: one UTF-16 code unit or an end-of-text marker per item.
// ----------------------------------------------------------------------------
interface csvt_in_if;
  logic                        valid;
  logic                        ready;
  logic [csvt_pkg::CharW-1:0]  char_code;
  logic                        end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

[hdl/csvt_out_if.sv]
// ----------------------------------------------------------------------------
// csvt_out_if
// Token channel: field characters, field/row/text ends and row marks.
// ----------------------------------------------------------------------------
interface csvt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        char_valid;
  logic [csvt_pkg::CharW-1:0]  char_out;
  logic                        field_end;
  logic                        row_end;
  logic                        text_end;
  logic                        row_is_header;
  logic                        row_kept;
  logic [csvt_pkg::CountW-1:0] data_row_count;

  modport source (
    output valid, output char_valid, output char_out, output field_end,
    output row_end, output text_end, output row_is_header, output row_kept,
    output data_row_count, input ready
  );
  modport sink (
    input valid, input char_valid, input char_out, input field_end,
    input row_end, input text_end, input row_is_header, input row_kept,
    input data_row_count, output ready
  );
endinterface

[hdl/csvt_in_reg.sv]
// ----------------------------------------------------------------------------
// csvt_in_reg
// Input register: captures one character item, releases it on advance.
// ----------------------------------------------------------------------------
module csvt_in_reg (
  input  logic               clk,
  input  logic               rst,
  csvt_in_if.sink            chars,
  input  logic               advance,
  output logic               item_valid,
  output csvt_pkg::in_item_t item
);

  logic load;

  assign chars.ready = !item_valid || advance;
  assign load        = chars.valid && chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (chars.ready) begin
      item_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item.char_code   <= chars.char_code;
      item.end_of_text <= chars.end_of_text;
    end
  end

endmodule

[hdl/csvt_parse.sv]
// ----------------------------------------------------------------------------
// csvt_parse
// Tokenizer state and the single-pass decode of one character item.
// ----------------------------------------------------------------------------
module csvt_parse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  csvt_pkg::in_item_t           item,
  input  logic [csvt_pkg::LimitW-1:0]  max_rows,
  output logic                         res_valid,
  output csvt_pkg::result_t            res
);

  logic at_text_start, inside_quotes, quote_pending, cr_pending;
  logic field_has_content, row_has_separator, header_seen;
  logic [csvt_pkg::CountW-1:0] data_rows_seen;

  logic at_text_start_next, inside_quotes_next, quote_pending_next, cr_pending_next;
  logic field_has_content_next, row_has_separator_next, header_seen_next;
  logic [csvt_pkg::CountW-1:0] data_rows_seen_next;

  logic                        hdr, kept, nonempty, go, unq, do_content, do_close;
  logic [csvt_pkg::CharW-1:0]  c, content_char;
  logic [csvt_pkg::CountW-1:0] count_inc;

  assign c    = item.char_code;
  assign hdr  = !header_seen;
  assign kept = hdr || (max_rows == '0) ||
                (data_rows_seen < {{(csvt_pkg::CountW-csvt_pkg::LimitW){1'b0}}, max_rows});
  assign nonempty  = row_has_separator || field_has_content;
  assign count_inc = (header_seen && data_rows_seen != csvt_pkg::CountMax) ?
                     data_rows_seen + 1'b1 : data_rows_seen;

  always_comb begin
    at_text_start_next     = at_text_start;
    inside_quotes_next     = inside_quotes;
    quote_pending_next     = quote_pending;
    cr_pending_next        = cr_pending;
    field_has_content_next = field_has_content;
    row_has_separator_next = row_has_separator;
    header_seen_next       = header_seen;
    data_rows_seen_next    = data_rows_seen;
    res_valid              = 1'b0;
    res                    = '0;
    res.data_row_count     = data_rows_seen;
    go                     = 1'b1;
    unq                    = 1'b0;
    do_content             = 1'b0;
    do_close               = 1'b0;
    content_char           = c;

    if (item.end_of_text) begin
      res_valid     = 1'b1;
      res.text_end  = 1'b1;
      if (nonempty) begin
        res.field_end      = 1'b1;
        res.row_end        = 1'b1;
        res.row_is_header  = hdr;
        res.row_kept       = kept;
        res.data_row_count = count_inc;
      end
      at_text_start_next     = 1'b1;
      inside_quotes_next     = 1'b0;
      quote_pending_next     = 1'b0;
      cr_pending_next        = 1'b0;
      field_has_content_next = 1'b0;
      row_has_separator_next = 1'b0;
      header_seen_next       = 1'b0;
      data_rows_seen_next    = '0;
    end else begin
      if (at_text_start) begin
        at_text_start_next = 1'b0;
        if (c == csvt_pkg::BomCode) go = 1'b0;
      end
      if (go && cr_pending) begin
        cr_pending_next = 1'b0;
        if (c == csvt_pkg::CharLf) go = 1'b0;
      end
      if (go) begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          if (c == csvt_pkg::CharQuote) begin
            do_content   = 1'b1;
            content_char = csvt_pkg::CharQuote;
          end else begin
            inside_quotes_next = 1'b0;
            unq                = 1'b1;
          end
        end else if (inside_quotes) begin
          if (c == csvt_pkg::CharQuote) quote_pending_next = 1'b1;
          else                          do_content         = 1'b1;
        end else begin
          unq = 1'b1;
        end
      end

      if (unq) begin
        priority if (c == csvt_pkg::CharQuote) begin
          inside_quotes_next = 1'b1;
        end else if (c == csvt_pkg::CharComma) begin
          row_has_separator_next = 1'b1;
          field_has_content_next = 1'b0;
          res_valid              = 1'b1;
          res.field_end          = 1'b1;
          res.row_is_header      = hdr;
          res.row_kept           = kept;
        end else if (c == csvt_pkg::CharCr || c == csvt_pkg::CharLf) begin
          cr_pending_next = (c == csvt_pkg::CharCr);
          do_close        = 1'b1;
        end else begin
          do_content = 1'b1;
        end
      end

      if (do_content) begin
        field_has_content_next = 1'b1;
        res_valid              = 1'b1;
        res.char_valid         = 1'b1;
        res.char_out           = content_char;
        res.row_is_header      = hdr;
        res.row_kept           = kept;
      end

      if (do_close) begin
        row_has_separator_next = 1'b0;
        field_has_content_next = 1'b0;
        if (nonempty) begin
          res_valid           = 1'b1;
          res.field_end       = 1'b1;
          res.row_end         = 1'b1;
          res.row_is_header   = hdr;
          res.row_kept        = kept;
          res.data_row_count  = count_inc;
          header_seen_next    = 1'b1;
          data_rows_seen_next = count_inc;
        end
      end
    end

    if (!step) res_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_text_start     <= 1'b1;
      inside_quotes     <= 1'b0;
      quote_pending     <= 1'b0;
      cr_pending        <= 1'b0;
      field_has_content <= 1'b0;
      row_has_separator <= 1'b0;
      header_seen       <= 1'b0;
      data_rows_seen    <= '0;
    end else if (step) begin
      at_text_start     <= at_text_start_next;
      inside_quotes     <= inside_quotes_next;
      quote_pending     <= quote_pending_next;
      cr_pending        <= cr_pending_next;
      field_has_content <= field_has_content_next;
      row_has_separator <= row_has_separator_next;
      header_seen       <= header_seen_next;
      data_rows_seen    <= data_rows_seen_next;
    end
  end

endmodule

[hdl/csvt_out_reg.sv]
// ----------------------------------------------------------------------------
// csvt_out_reg
// Result register driving the token channel.
// ----------------------------------------------------------------------------
module csvt_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  csvt_pkg::result_t res,
  output logic              can_take,
  csvt_out_if.source        tokens
);

  csvt_pkg::result_t held;

  assign can_take = !tokens.valid || tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tokens.valid <= 1'b0;
    end else if (can_take) begin
      tokens.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      held <= res;
    end
  end

  assign tokens.char_valid     = held.char_valid;
  assign tokens.char_out       = held.char_out;
  assign tokens.field_end      = held.field_end;
  assign tokens.row_end        = held.row_end;
  assign tokens.text_end       = held.text_end;
  assign tokens.row_is_header  = held.row_is_header;
  assign tokens.row_kept       = held.row_kept;
  assign tokens.data_row_count = held.data_row_count;

endmodule

[hdl/csv_stream_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_core
// Streaming CSV tokenizer, one UTF-16 code unit per item.
//
//   channel   dir   payload                                 handshake
//   chars     in    char_code[15:0], end_of_text            valid/ready
//   tokens    out   char flags, row marks, count[31:0]      valid/ready
//   cfg       in    cfg_wdata[23:0] = max_rows              cfg_we, no ready
//
// One item per clock while tokens do not stall.
// Decode runs in one pass between the input register and the result register.
// Items that produce no token still pass the decode slot and update state.
// A stall on tokens holds the result and backs up into the input register.
// rst is synchronous; max_rows resets to 0 (keep every row).
// ----------------------------------------------------------------------------
`include "csv_stream_tokenizer_core_assert.svh"

module csv_stream_tokenizer_core (
  input  logic                        clk,
  input  logic                        rst,
  csvt_in_if.sink                     chars,
  csvt_out_if.source                  tokens,
  input  logic                        cfg_we,
  input  logic [csvt_pkg::LimitW-1:0] cfg_wdata
);

  logic                        item_valid;
  csvt_pkg::in_item_t          item;
  logic                        can_take;
  logic                        step;
  logic                        res_valid;
  csvt_pkg::result_t           res;
  logic [csvt_pkg::LimitW-1:0] max_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_rows <= '0;
    end else if (cfg_we) begin
      max_rows <= cfg_wdata;
    end
  end

  assign step = item_valid && can_take;

  csvt_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .advance    (can_take),
    .item_valid (item_valid),
    .item       (item)
  );

  csvt_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .max_rows  (max_rows),
    .res_valid (res_valid),
    .res       (res)
  );

  csvt_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .tokens    (tokens)
  );

  `CSVT_ASSERT_NOW(a_row_end_has_field_end, tokens.valid && tokens.row_end, tokens.field_end, "row end without field end")
  `CSVT_ASSERT_NOW(a_char_not_field_end, tokens.valid && tokens.char_valid, !tokens.field_end && !tokens.text_end, "character item also marks an end")
  `CSVT_ASSERT_NOW(a_header_kept, tokens.valid && tokens.row_is_header, tokens.row_kept, "header row not kept")
  `CSVT_ASSERT_NEXT(a_accept_loads, chars.valid && chars.ready, item_valid, "accepted item not held in input register")

endmodule
